>>> rtl/core/tlpt_pkg.sv
// Shared types and constants for the two-level page table engine.
package tlpt_pkg;

    localparam int ADDR_W      = 32;
    localparam int REQ_W       = 2;
    localparam int FLAG_W      = 12;
    localparam int STAT_W      = 2;
    localparam int OFF_W       = 12;
    localparam int IDX_W       = 10;
    localparam int ENTRY_W     = 32;
    localparam int DIR_ENTRIES = 1024;

    localparam logic [REQ_W-1:0] REQ_MAP   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UNMAP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_XLATE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0] frame_addr;
        logic [FLAG_W-1:0] page_flags;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] phys_out;
        logic              present;
    } rsp_t;

endpackage

>>> rtl/core/tlpt_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module tlpt_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/tlpt_ctrl.sv
// Request sequencer: directory and table lookups, table allocation and clearing, result register.
module tlpt_ctrl #(
    parameter int TABLE_SLOTS = 8,
    parameter int SLOT_W      = 3,
    parameter int CNT_W       = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tlpt_pkg::req_t                       req,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tlpt_pkg::rsp_t                       rsp,
    output logic                                 dir_rd_en,
    output logic [tlpt_pkg::IDX_W-1:0]           dir_rd_addr,
    input  logic [SLOT_W:0]                      dir_rd_data,
    output logic                                 dir_we,
    output logic [tlpt_pkg::IDX_W-1:0]           dir_wr_addr,
    output logic [SLOT_W:0]                      dir_wr_data,
    output logic                                 tbl_rd_en,
    output logic [SLOT_W+tlpt_pkg::IDX_W-1:0]    tbl_rd_addr,
    input  logic [tlpt_pkg::ENTRY_W-1:0]         tbl_rd_data,
    output logic                                 tbl_we,
    output logic [SLOT_W+tlpt_pkg::IDX_W-1:0]    tbl_wr_addr,
    output logic [tlpt_pkg::ENTRY_W-1:0]         tbl_wr_data
);

    localparam int IDX_W  = tlpt_pkg::IDX_W;
    localparam int ADDR_W = tlpt_pkg::ADDR_W;
    localparam int OFF_W  = tlpt_pkg::OFF_W;

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DIR  = 3'd2;
    localparam logic [2:0] ST_TBL  = 3'd3;
    localparam logic [2:0] ST_CLR  = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    tlpt_pkg::req_t       req_reg, req_next;
    logic                 out_valid_reg, out_valid_next;
    tlpt_pkg::rsp_t       out_rsp_reg, out_rsp_next;
    tlpt_pkg::rsp_t       pend_rsp_reg, pend_rsp_next;

    logic                 accept;
    logic                 out_free;
    logic                 fin;
    tlpt_pkg::rsp_t       fin_rsp;
    logic [IDX_W-1:0]     di;
    logic [IDX_W-1:0]     ti;
    logic                 dir_hit;
    logic [SLOT_W-1:0]    dir_slot;
    logic [tlpt_pkg::ENTRY_W-1:0] new_entry;
    logic                 pool_full;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

    assign di        = req_reg.virt_addr[ADDR_W-1 -: IDX_W];
    assign ti        = req_reg.virt_addr[ADDR_W-IDX_W-1 -: IDX_W];
    assign dir_hit   = dir_rd_data[SLOT_W];
    assign dir_slot  = dir_rd_data[SLOT_W-1:0];
    assign new_entry = {req_reg.frame_addr[ADDR_W-1:OFF_W], req_reg.page_flags};
    assign pool_full = (used_reg >= CNT_W'(TABLE_SLOTS));

    // The directory read goes out in the accept cycle, straight from the input port.
    assign dir_rd_en   = accept;
    assign dir_rd_addr = req.virt_addr[ADDR_W-1 -: IDX_W];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        used_next      = used_reg;
        req_next       = req_reg;
        pend_rsp_next  = pend_rsp_reg;
        out_rsp_next   = out_rsp_reg;
        out_valid_next = out_valid_reg && !out_ready;

        fin              = 1'b0;
        fin_rsp.status   = tlpt_pkg::STAT_MISS;
        fin_rsp.phys_out = '0;
        fin_rsp.present  = 1'b0;

        dir_we      = 1'b0;
        dir_wr_addr = di;
        dir_wr_data = {1'b1, used_reg[SLOT_W-1:0]};
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = {dir_slot, ti};
        tbl_we      = 1'b0;
        tbl_wr_addr = {dir_slot, ti};
        tbl_wr_data = '0;

        case (state_reg)
            ST_INIT:
            begin
                // Clear every directory entry once after reset.
                dir_we      = 1'b1;
                dir_wr_addr = cnt_reg;
                dir_wr_data = '0;
                cnt_next    = cnt_reg + IDX_W'(1);
                if (cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req;
                    state_next = ST_DIR;
                end
            end
            ST_DIR:
            begin
                case (req_reg.req_type)
                    tlpt_pkg::REQ_MAP:
                    begin
                        if (dir_hit)
                        begin
                            tbl_we         = 1'b1;
                            tbl_wr_data    = new_entry;
                            fin            = 1'b1;
                            fin_rsp.status = tlpt_pkg::STAT_OK;
                        end
                        else if (pool_full)
                        begin
                            fin            = 1'b1;
                            fin_rsp.status = tlpt_pkg::STAT_FULL;
                        end
                        else
                        begin
                            dir_we     = 1'b1;
                            slot_next  = used_reg[SLOT_W-1:0];
                            used_next  = used_reg + CNT_W'(1);
                            cnt_next   = '0;
                            state_next = ST_CLR;
                        end
                    end
                    tlpt_pkg::REQ_UNMAP:
                    begin
                        fin = 1'b1;
                        if (dir_hit)
                        begin
                            tbl_we         = 1'b1;
                            fin_rsp.status = tlpt_pkg::STAT_OK;
                        end
                    end
                    tlpt_pkg::REQ_XLATE:
                    begin
                        if (dir_hit)
                        begin
                            tbl_rd_en  = 1'b1;
                            state_next = ST_TBL;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_TBL:
            begin
                fin = 1'b1;
                if (tbl_rd_data[0])
                begin
                    fin_rsp.status   = tlpt_pkg::STAT_OK;
                    fin_rsp.present  = 1'b1;
                    fin_rsp.phys_out = {tbl_rd_data[ADDR_W-1:OFF_W],
                                        req_reg.virt_addr[OFF_W-1:0]};
                end
            end
            ST_CLR:
            begin
                // Sweep the new table, dropping the mapped entry in on its own index.
                tbl_we      = 1'b1;
                tbl_wr_addr = {slot_reg, cnt_reg};
                tbl_wr_data = (cnt_reg == ti) ? new_entry : '0;
                cnt_next    = cnt_reg + IDX_W'(1);
                if (cnt_reg == '1)
                begin
                    fin            = 1'b1;
                    fin_rsp.status = tlpt_pkg::STAT_OK;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rsp_next   = pend_rsp_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_rsp_next   = fin_rsp;
                state_next     = ST_IDLE;
            end
            else
            begin
                pend_rsp_next = fin_rsp;
                state_next    = ST_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        req_reg      <= req_next;
        out_rsp_reg  <= out_rsp_next;
        pend_rsp_reg <= pend_rsp_next;
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_SLOTS))
        else $error("table pool count exceeds the number of slots");

    a_clr_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> (CNT_W'(slot_reg) < used_reg))
        else $error("clearing a table slot that was never allocated");

    a_accept_dir: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIR))
        else $error("accepted request did not start its directory lookup");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> out_valid_reg)
        else $error("result parked while the output register is empty");

    a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rsp_reg.present) |-> (out_rsp_reg.status == tlpt_pkg::STAT_OK))
        else $error("present result carries an error status");

endmodule

>>> rtl/core/two_level_page_table_engine_top.sv
// Top level of the two-level page table engine: sequencer plus directory and table RAMs.
//
//  channel | signals                                            | direction
//  --------+----------------------------------------------------+----------
//  request | in_valid, in_ready, req_type, virt_addr,           | in
//          | frame_addr, page_flags                             |
//  result  | out_valid, out_ready, status, phys_out, present    | out
//
// A translate that finds a table steps through accept, directory read and table read,
// then registers its result. Every other request without a new table registers its
// result straight after the directory read.
// A map that allocates a table also sweeps all 1024 entries of it.
// After reset the directory RAM is cleared one entry a cycle, all 1024 entries; in_ready
// stays low meanwhile. One request is in flight at a time; a finished result waits while
// the output register is full, and the next request is taken in the cycle after it moves in.
module two_level_page_table_engine_top #(
    parameter int TABLE_SLOTS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tlpt_pkg::REQ_W-1:0]      req_type,
    input  logic [tlpt_pkg::ADDR_W-1:0]     virt_addr,
    input  logic [tlpt_pkg::ADDR_W-1:0]     frame_addr,
    input  logic [tlpt_pkg::FLAG_W-1:0]     page_flags,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tlpt_pkg::STAT_W-1:0]     status,
    output logic [tlpt_pkg::ADDR_W-1:0]     phys_out,
    output logic                            present
);

    localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int IDX_W     = tlpt_pkg::IDX_W;
    localparam int TBL_AW    = SLOT_W + IDX_W;
    localparam int TBL_DEPTH = TABLE_SLOTS * tlpt_pkg::DIR_ENTRIES;

    tlpt_pkg::req_t req;
    tlpt_pkg::rsp_t rsp;

    logic                          dir_rd_en;
    logic [IDX_W-1:0]              dir_rd_addr;
    logic [SLOT_W:0]               dir_rd_data;
    logic                          dir_we;
    logic [IDX_W-1:0]              dir_wr_addr;
    logic [SLOT_W:0]               dir_wr_data;
    logic                          tbl_rd_en;
    logic [TBL_AW-1:0]             tbl_rd_addr;
    logic [tlpt_pkg::ENTRY_W-1:0]  tbl_rd_data;
    logic                          tbl_we;
    logic [TBL_AW-1:0]             tbl_wr_addr;
    logic [tlpt_pkg::ENTRY_W-1:0]  tbl_wr_data;

    assign req.req_type   = req_type;
    assign req.virt_addr  = virt_addr;
    assign req.frame_addr = frame_addr;
    assign req.page_flags = page_flags;

    assign status   = rsp.status;
    assign phys_out = rsp.phys_out;
    assign present  = rsp.present;

    tlpt_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req         (req),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rsp         (rsp),
        .dir_rd_en   (dir_rd_en),
        .dir_rd_addr (dir_rd_addr),
        .dir_rd_data (dir_rd_data),
        .dir_we      (dir_we),
        .dir_wr_addr (dir_wr_addr),
        .dir_wr_data (dir_wr_data),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data),
        .tbl_we      (tbl_we),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data)
    );

    // Directory entry: valid bit above the pool slot number.
    tlpt_ram #(
        .DEPTH  (tlpt_pkg::DIR_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (SLOT_W + 1)
    ) u_dir_ram (
        .clk     (clk),
        .we      (dir_we),
        .wr_addr (dir_wr_addr),
        .wr_data (dir_wr_data),
        .rd_en   (dir_rd_en),
        .rd_addr (dir_rd_addr),
        .rd_data (dir_rd_data)
    );

    tlpt_ram #(
        .DEPTH  (TBL_DEPTH),
        .ADDR_W (TBL_AW),
        .DATA_W (tlpt_pkg::ENTRY_W)
    ) u_tbl_ram (
        .clk     (clk),
        .we      (tbl_we),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

endmodule

>>> tb/tb_two_level_page_table_engine_top.sv
// Self-checking testbench for the two-level page table engine top level.
`timescale 1ns / 1ps

module tb_two_level_page_table_engine_top;

    localparam int REQ_W       = tlpt_pkg::REQ_W;
    localparam int ADDR_W      = tlpt_pkg::ADDR_W;
    localparam int FLAG_W      = tlpt_pkg::FLAG_W;
    localparam int STAT_W      = tlpt_pkg::STAT_W;
    localparam int IDX_W       = tlpt_pkg::IDX_W;
    localparam int OFF_W       = tlpt_pkg::OFF_W;
    localparam int ENTRY_W     = tlpt_pkg::ENTRY_W;
    localparam int DIR_ENTRIES = tlpt_pkg::DIR_ENTRIES;

    localparam int TABLE_SLOTS = 8;
    localparam int PTE_WORDS   = TABLE_SLOTS * 1024;
    localparam int IDLE_LIMIT  = 8000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_REQS = 750;
    localparam int HOLD_AFTER  = 120;
    localparam int HOLD_CYCLES = 250;
    localparam logic [REQ_W-1:0] REQ_BAD = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type = '0;
    logic [ADDR_W-1:0]   virt_addr = '0;
    logic [ADDR_W-1:0]   frame_addr = '0;
    logic [FLAG_W-1:0]   page_flags = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STAT_W-1:0]   status;
    logic [ADDR_W-1:0]   phys_out;
    logic                present;

    // Shadow copy of the directory, the table pool and the allocation count.
    bit                  dir_valid [DIR_ENTRIES];
    int unsigned         dir_slot [DIR_ENTRIES];
    bit [ENTRY_W-1:0]    pte_mem [PTE_WORDS];
    int unsigned         slots_used = 0;

    tlpt_pkg::req_t      request_q [$];
    tlpt_pkg::rsp_t      walk_results_q [$];
    tlpt_pkg::req_t      drive_req;
    tlpt_pkg::req_t      seen_req;
    tlpt_pkg::rsp_t      want;

    bit                  req_accepted = 1'b0;
    int                  sent_count = 0;
    int                  rsp_count = 0;
    int                  err_count = 0;
    int                  idle_cycles = 0;
    int                  hold_cnt = 0;
    bit                  hold_done = 1'b0;

    logic [IDX_W-1:0]    live_dirs [8];
    logic [IDX_W-1:0]    hot_ti [16];

    two_level_page_table_engine_top #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .virt_addr  (virt_addr),
        .frame_addr (frame_addr),
        .page_flags (page_flags),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .phys_out   (phys_out),
        .present    (present)
    );

    always
    begin
        #4;
        clk = 1'b1;
        #4;
        clk = 1'b0;
    end

    // Walks the shadow tables for one request and updates them as the block would.
    function automatic tlpt_pkg::rsp_t page_walk(tlpt_pkg::req_t r);
        tlpt_pkg::rsp_t   res;
        int unsigned      di;
        int unsigned      ti;
        int unsigned      base;
        bit               have;
        bit [ENTRY_W-1:0] pte;
        res.status   = tlpt_pkg::STAT_MISS;
        res.phys_out = '0;
        res.present  = 1'b0;
        di   = 32'(r.virt_addr[31:22]);
        ti   = 32'(r.virt_addr[21:12]);
        have = dir_valid[di];
        base = dir_slot[di] * 1024;
        case (r.req_type)
            tlpt_pkg::REQ_MAP:
            begin
                if (!have)
                begin
                    if (slots_used >= TABLE_SLOTS)
                    begin
                        res.status = tlpt_pkg::STAT_FULL;
                    end
                    else
                    begin
                        dir_valid[di] = 1'b1;
                        dir_slot[di]  = slots_used;
                        base = slots_used * 1024;
                        for (int k = 0; k < 1024; k++)
                        begin
                            pte_mem[base + k] = '0;
                        end
                        slots_used++;
                        have = 1'b1;
                    end
                end
                if (have)
                begin
                    pte_mem[base + ti] = {r.frame_addr[31:12], r.page_flags};
                    res.status = tlpt_pkg::STAT_OK;
                end
            end
            tlpt_pkg::REQ_UNMAP:
            begin
                if (have)
                begin
                    pte_mem[base + ti] = '0;
                    res.status = tlpt_pkg::STAT_OK;
                end
            end
            tlpt_pkg::REQ_XLATE:
            begin
                if (have)
                begin
                    pte = pte_mem[base + ti];
                    if (pte[0])
                    begin
                        res.status   = tlpt_pkg::STAT_OK;
                        res.present  = 1'b1;
                        res.phys_out = {pte[31:12], 12'h000} + {20'h0, r.virt_addr[11:0]};
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic add_request(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] di,
                               input logic [IDX_W-1:0] ti, input logic [OFF_W-1:0] off,
                               input logic [ADDR_W-1:0] pa, input logic [FLAG_W-1:0] flags);
        tlpt_pkg::req_t r;
        r.req_type   = kind;
        r.virt_addr  = {di, ti, off};
        r.frame_addr = pa;
        r.page_flags = flags;
        request_q.push_back(r);
    endtask

    initial
    begin
        logic [REQ_W-1:0]  kind;
        logic [IDX_W-1:0]  di;
        logic [IDX_W-1:0]  ti;
        logic [ADDR_W-1:0] va;
        logic [FLAG_W-1:0] flags;
        int                pick;

        live_dirs = '{10'd0, 10'd1023, 10'd1, 10'd3, 10'h155, 10'h2AA, 10'h100, 10'h200};
        hot_ti[0] = 10'd0;
        hot_ti[1] = 10'd1023;
        hot_ti[2] = 10'd1;
        hot_ti[3] = 10'd5;
        for (int k = 4; k < 16; k++)
        begin
            hot_ti[k] = IDX_W'($urandom);
        end

        // Empty tables, an unknown request type, then the first table.
        add_request(tlpt_pkg::REQ_XLATE, 10'd0, 10'd0, 12'h000, 32'h0, 12'h000);
        add_request(tlpt_pkg::REQ_UNMAP, 10'd0, 10'd0, 12'h000, 32'h0, 12'h000);
        add_request(REQ_BAD, 10'd0, 10'd0, 12'hFFF, 32'hFFFF_FFFF, 12'hFFF);
        add_request(tlpt_pkg::REQ_MAP, 10'd0, 10'd0, 12'h000, 32'hFFFF_FFFF, 12'hFFF);
        add_request(tlpt_pkg::REQ_XLATE, 10'd0, 10'd0, 12'hFFF, 32'h0, 12'h000);
        // A mapped entry without the present bit translates as a miss.
        add_request(tlpt_pkg::REQ_MAP, 10'd0, 10'd1, 12'h123, 32'h1234_5678, 12'hFFE);
        add_request(tlpt_pkg::REQ_XLATE, 10'd0, 10'd1, 12'h456, 32'h0, 12'h000);
        add_request(tlpt_pkg::REQ_UNMAP, 10'd0, 10'd0, 12'hABC, 32'h0, 12'h000);
        add_request(tlpt_pkg::REQ_XLATE, 10'd0, 10'd0, 12'h000, 32'h0, 12'h000);
        add_request(tlpt_pkg::REQ_XLATE, 10'd0, 10'd5, 12'h000, 32'h0, 12'h000);
        add_request(tlpt_pkg::REQ_MAP, 10'd1023, 10'd1023, 12'hFFF, 32'h0000_0FFF, 12'h001);
        add_request(tlpt_pkg::REQ_XLATE, 10'd1023, 10'd1023, 12'hFFF, 32'h0, 12'h000);
        for (int k = 2; k < 8; k++)
        begin
            add_request(tlpt_pkg::REQ_MAP, live_dirs[k], hot_ti[k], OFF_W'($urandom),
                        $urandom, FLAG_W'($urandom) | 12'h001);
        end
        // The pool is now full: a new directory entry cannot get a table.
        add_request(tlpt_pkg::REQ_MAP, 10'h3FE, 10'd7, 12'h000, 32'hDEAD_B000, 12'h001);
        add_request(tlpt_pkg::REQ_XLATE, 10'h3FE, 10'd7, 12'h000, 32'h0, 12'h000);
        add_request(tlpt_pkg::REQ_UNMAP, 10'h3FE, 10'd7, 12'h000, 32'h0, 12'h000);
        // Unmapping does not release the slot, so a remap still succeeds.
        add_request(tlpt_pkg::REQ_UNMAP, 10'd1023, 10'd1023, 12'h000, 32'h0, 12'h000);
        add_request(tlpt_pkg::REQ_MAP, 10'd1023, 10'd1023, 12'h000, $urandom, 12'h001);
        add_request(tlpt_pkg::REQ_XLATE, 10'd1023, 10'd1023, OFF_W'($urandom), 32'h0,
                    12'h000);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if ($urandom_range(99) < 15)
            begin
                va = $urandom;
                add_request(REQ_W'($urandom_range(3)), va[31:22], va[21:12], va[11:0],
                            $urandom, FLAG_W'($urandom));
            end
            else
            begin
                di = ($urandom_range(99) < 90) ? live_dirs[$urandom_range(7)]
                                               : IDX_W'($urandom);
                ti = ($urandom_range(99) < 90) ? hot_ti[$urandom_range(15)]
                                               : IDX_W'($urandom);
                flags = FLAG_W'($urandom);
                flags[0] = ($urandom_range(99) < 75);
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    kind = tlpt_pkg::REQ_MAP;
                end
                else if (pick < 50)
                begin
                    kind = tlpt_pkg::REQ_UNMAP;
                end
                else if (pick < 95)
                begin
                    kind = tlpt_pkg::REQ_XLATE;
                end
                else
                begin
                    kind = REQ_BAD;
                end
                add_request(kind, di, ti, OFF_W'($urandom), $urandom, flags);
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Checked just after each rising edge, when the driver and monitor are settled.
        do
        begin
            @(posedge clk);
            #1;
        end
        while (request_q.size() != 0 || in_valid || walk_results_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (walk_results_q.size() != 0)
        begin
            err_count++;
        end
        if (err_count == 0)
        begin
            $display("two_level_page_table_engine_top test passed");
        end
        else
        begin
            $display("two_level_page_table_engine_top test failed");
        end
        $finish;
    end

    // Request driver: holds each request until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || req_accepted)
        begin
            if (request_q.size() > 0 &&
                ((sent_count >= 300 && sent_count < 450) || $urandom_range(99) >= 18))
            begin
                drive_req = request_q.pop_front();
                req_type   <= drive_req.req_type;
                virt_addr  <= drive_req.virt_addr;
                frame_addr <= drive_req.frame_addr;
                page_flags <= drive_req.page_flags;
                in_valid   <= 1'b1;
                sent_count++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, one long hold-off, and a stretch without stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (rsp_count >= HOLD_AFTER && !hold_done)
        begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (rsp_count >= 400 && rsp_count < 550) || $urandom_range(99) >= 18;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (walk_results_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                begin
                    $display("%0t: result with none expected: status %0d phys_out %h present %b",
                             $realtime, status, phys_out, present);
                end
            end
            else
            begin
                want = walk_results_q.pop_front();
                if (status !== want.status || phys_out !== want.phys_out ||
                    present !== want.present)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("%0t: result %0d: expected status %0d phys_out %h present %b,",
                                 $realtime, rsp_count, want.status, want.phys_out,
                                 want.present);
                        $display("    got status %0d phys_out %h present %b",
                                 status, phys_out, present);
                    end
                end
            end
            rsp_count++;
        end
        if (in_valid && in_ready)
        begin
            seen_req.req_type   = req_type;
            seen_req.virt_addr  = virt_addr;
            seen_req.frame_addr = frame_addr;
            seen_req.page_flags = page_flags;
            walk_results_q.push_back(page_walk(seen_req));
        end
        req_accepted = in_valid && in_ready;
    end

    // Watchdog: the directory clear after reset and each table allocation are the longest
    // quiet periods; the limit sits well beyond them.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("two_level_page_table_engine_top test failed");
            $finish;
        end
    end

endmodule

>>> sim.f
rtl/core/tlpt_pkg.sv
rtl/core/tlpt_ram.sv
rtl/core/tlpt_ctrl.sv
rtl/core/two_level_page_table_engine_top.sv
tb/tb_two_level_page_table_engine_top.sv
